### rtl/rgb2hsv_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants and the reciprocal table for the rgb to hsv pixel pipeline
// no dependencies; used by the interfaces, the divider and the top level

package rgb2hsv_pkg;

  // field widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 13;
  localparam int unsigned SatW  = 8;

  // hue numerator: 960 * (offset * delta + diff), offset*delta+diff stays below 6*256
  localparam int unsigned SumW     = 11;
  localparam int unsigned HueNumW  = 21;
  // saturation numerator: delta * 255
  localparam int unsigned SatNumW  = 16;

  // sector offsets in units of 60 degrees; the wrapped red sector counts as six
  localparam int unsigned OffW = 3;
  localparam logic [OffW-1:0] OffRed     = 3'd0;
  localparam logic [OffW-1:0] OffGreen   = 3'd2;
  localparam logic [OffW-1:0] OffBlue    = 3'd4;
  localparam logic [OffW-1:0] OffRedWrap = 3'd6;

  // reciprocal ceil(2^RecipShift / d), exact floor division for numerators below 2^21
  localparam int unsigned RecipShift = 29;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned TabDepth   = 1 << ChanW;

  typedef logic [TabDepth-1:0][RecipW-1:0] recip_tab_t;

  // built at elaboration by shift and subtract; entry zero is unused
  function automatic recip_tab_t build_recip_tab();
    recip_tab_t  tab;
    logic [31:0] num;
    logic [31:0] rem;
    logic [31:0] quo;
    for (int d = 0; d < TabDepth; d++) begin
      tab[d] = '0;
      if (d != 0) begin
        num = (32'd1 << RecipShift) + 32'(d) - 32'd1;
        rem = '0;
        quo = '0;
        for (int i = 31; i >= 0; i--) begin
          rem = {rem[30:0], num[i]};
          if (rem >= 32'(d)) begin
            rem    = rem - 32'(d);
            quo[i] = 1'b1;
          end
        end
        tab[d] = quo[RecipW-1:0];
      end
    end
    return tab;
  endfunction

  localparam recip_tab_t RecipTab = build_recip_tab();

endpackage

### rtl/rgb2hsv_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for rgb pixel words in and hsv words out
// depends on rgb2hsv_pkg for field widths

interface rgb2hsv_pix_if;
  logic                              valid;
  logic                              ready;
  logic [rgb2hsv_pkg::ChanW-1:0]     red;
  logic [rgb2hsv_pkg::ChanW-1:0]     green;
  logic [rgb2hsv_pkg::ChanW-1:0]     blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgb2hsv_hsv_if;
  logic                              valid;
  logic                              ready;
  logic [rgb2hsv_pkg::HueW-1:0]      hue;
  logic [rgb2hsv_pkg::SatW-1:0]      saturation;
  logic [rgb2hsv_pkg::ChanW-1:0]     brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

### rtl/rgb2hsv_div.sv
`timescale 1ns / 1ps
// two-stage divider by an 8-bit divisor: reciprocal table lookup, then multiply and shift
// depends on rgb2hsv_pkg for the reciprocal table

module rgb2hsv_div #(
  parameter int unsigned NUM_W  = rgb2hsv_pkg::HueNumW,
  parameter int unsigned QUOT_W = rgb2hsv_pkg::HueW
) (
  input  logic                          clk_i,
  input  logic                          lookup_en_i,
  input  logic                          mul_en_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [rgb2hsv_pkg::ChanW-1:0] den_i,
  output logic [QUOT_W-1:0]             quot_o
);

  localparam int unsigned ProdW = NUM_W + rgb2hsv_pkg::RecipW;

  logic [NUM_W-1:0]               num_q;
  logic [rgb2hsv_pkg::RecipW-1:0] recip_q;
  logic [ProdW-1:0]               prod_q;

  // lookup stage: hold numerator and reciprocal of the divisor
  always_ff @(posedge clk_i) begin
    if (lookup_en_i) begin
      num_q   <= num_i;
      recip_q <= rgb2hsv_pkg::RecipTab[den_i];
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= ProdW'(num_q) * ProdW'(recip_q);
    end
  end

  // the quotient is the product scaled down by the reciprocal's shift
  assign quot_o = prod_q[rgb2hsv_pkg::RecipShift +: QUOT_W];

endmodule

### rtl/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps
// rgb to hsv pixel converter, four register stages with a valid bit per stage
// depends on rgb2hsv_pkg, rgb2hsv_if and rgb2hsv_div
//
//   channel | dir | word fields
//   --------+-----+-----------------------------------------------
//   pix_i   | in  | red[7:0], green[7:0], blue[7:0]
//   hsv_o   | out | hue[12:0], saturation[7:0], brightness[7:0]
//
// one pixel a clock sustained while hsv_o is ready; a pixel passes through the stages
// max/min, numerator plus reciprocal lookup, multiply, output, on its way to a valid hsv word.
// reset clears only the valid bits; the data path holds no state between pixels.
// a stage takes a new word when it is empty or its successor takes its word, so a
// stall on hsv_o backs up through the stages without losing or repeating words.

module rgb_to_hsv_pixel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgb2hsv_pix_if.sink          pix_i,
  rgb2hsv_hsv_if.source        hsv_o
);

  localparam int unsigned ChanW = rgb2hsv_pkg::ChanW;

  // stage valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || hsv_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: max, min, sector and signed difference
  logic [ChanW-1:0]                   rg_hi, rg_lo, hi_d, lo_d;
  logic signed [ChanW:0]              diff_d;
  logic [rgb2hsv_pkg::OffW-1:0]       off_d;
  logic [ChanW-1:0]                   hi1_q, delta1_q;
  logic signed [ChanW:0]              diff1_q;
  logic [rgb2hsv_pkg::OffW-1:0]       off1_q;

  always_comb begin
    rg_hi = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    rg_lo = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    hi_d  = (pix_i.blue > rg_hi) ? pix_i.blue : rg_hi;
    lo_d  = (pix_i.blue < rg_lo) ? pix_i.blue : rg_lo;
    // red wins ties over green, green over blue
    if (pix_i.red >= hi_d) begin
      diff_d = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
      off_d  = (diff_d < 0) ? rgb2hsv_pkg::OffRedWrap : rgb2hsv_pkg::OffRed;
    end else if (pix_i.green >= hi_d) begin
      diff_d = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
      off_d  = rgb2hsv_pkg::OffGreen;
    end else begin
      diff_d = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
      off_d  = rgb2hsv_pkg::OffBlue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      hi1_q    <= hi_d;
      delta1_q <= hi_d - lo_d;
      diff1_q  <= diff_d;
      off1_q   <= off_d;
    end
  end

  // stage 2 inputs: hue and saturation numerators
  logic [ChanW+2:0]                   off_delta;
  logic signed [rgb2hsv_pkg::SumW:0]  sum_s;
  logic [rgb2hsv_pkg::SumW-1:0]       sum_u;
  logic [rgb2hsv_pkg::HueNumW-1:0]    hue_num;
  logic [rgb2hsv_pkg::SatNumW-1:0]    sat_num;

  always_comb begin
    off_delta = (ChanW + 3)'(delta1_q) * (ChanW + 3)'(off1_q);
    sum_s     = $signed({1'b0, off_delta}) + (rgb2hsv_pkg::SumW + 1)'(diff1_q);
    sum_u     = sum_s[rgb2hsv_pkg::SumW-1:0];
    // times 960 = 1024 - 64
    hue_num   = {sum_u, 10'd0} - {4'd0, sum_u, 6'd0};
    // times 255 = 256 - 1
    sat_num   = {delta1_q, 8'd0} - {8'd0, delta1_q};
  end

  logic [ChanW-1:0] hi2_q, hi3_q;
  logic             grey2_q, grey3_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      hi2_q   <= hi1_q;
      grey2_q <= (delta1_q == '0);
    end
    if (en3) begin
      hi3_q   <= hi2_q;
      grey3_q <= grey2_q;
    end
  end

  // stages 2 and 3: the two divisions
  logic [rgb2hsv_pkg::HueW-1:0] hue_quot;
  logic [rgb2hsv_pkg::SatW-1:0] sat_quot;

  rgb2hsv_div #(
    .NUM_W  (rgb2hsv_pkg::HueNumW),
    .QUOT_W (rgb2hsv_pkg::HueW)
  ) u_hue_div (
    .clk_i       (clk_i),
    .lookup_en_i (en2),
    .mul_en_i    (en3),
    .num_i       (hue_num),
    .den_i       (delta1_q),
    .quot_o      (hue_quot)
  );

  rgb2hsv_div #(
    .NUM_W  (rgb2hsv_pkg::SatNumW),
    .QUOT_W (rgb2hsv_pkg::SatW)
  ) u_sat_div (
    .clk_i       (clk_i),
    .lookup_en_i (en2),
    .mul_en_i    (en3),
    .num_i       (sat_num),
    .den_i       (hi1_q),
    .quot_o      (sat_quot)
  );

  // stage 4: output word, grey pixels give zero hue and saturation
  logic [rgb2hsv_pkg::HueW-1:0] hue_q;
  logic [rgb2hsv_pkg::SatW-1:0] sat_q;
  logic [ChanW-1:0]             bright_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hue_q    <= grey3_q ? '0 : hue_quot;
      sat_q    <= grey3_q ? '0 : sat_quot;
      bright_q <= hi3_q;
    end
  end

  assign hsv_o.valid      = v4_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bright_q;

endmodule

### tb/sv/rgb_to_hsv_pixel_test.sv
`timescale 1ns / 1ps
// self-checking bench for rgb_to_hsv_pixel: directed corners, random pixels and stalls on both sides
// depends on rgb2hsv_pkg, rgb2hsv_if and the rgb_to_hsv_pixel top level

module rgb_to_hsv_pixel_test;

  // field widths
  localparam int unsigned ChanW = rgb2hsv_pkg::ChanW;
  localparam int unsigned HueW  = rgb2hsv_pkg::HueW;
  localparam int unsigned SatW  = rgb2hsv_pkg::SatW;

  // cycles with no word moving on either side before the run is abandoned
  localparam int unsigned IdleLimit   = 4000;
  // quiet cycles after the last hsv word
  localparam int unsigned DrainCycles = 16;

  // hue arithmetic in sixteenths of a degree
  localparam int SectorGreen         = 2;
  localparam int SectorBlue          = 4;
  localparam int SixteenthsPerSector = 960;
  localparam int SixteenthsFullTurn  = 5760;
  localparam int SatScale            = 255;

  // corner pixels packed as {red, green, blue}
  localparam logic [23:0] CornerPixels [22] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100,
    24'h010000, 24'h000100, 24'h000001, 24'hFFFE00, 24'h00FFFE, 24'hFE00FF,
    24'h7F8080, 24'h807F7F, 24'hFF7F80, 24'h10E0C8
  };

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [SatW-1:0]  saturation;
    logic [ChanW-1:0] brightness;
  } hsv_word_t;

  logic clk_i;
  logic rst_ni;

  rgb2hsv_pix_if pix_bus ();
  rgb2hsv_hsv_if hsv_bus ();

  rgb_to_hsv_pixel i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .hsv_o  (hsv_bus)
  );

  hsv_word_t   expected_hsv [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          steady_flow    = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // exact integer conversion of one pixel
  function automatic hsv_word_t predict_hsv(input chan_t r, input chan_t g, input chan_t b);
    hsv_word_t word;
    int        red;
    int        green;
    int        blue;
    int        peak;
    int        trough;
    int        span;
    int        num;
    red    = int'(r);
    green  = int'(g);
    blue   = int'(b);
    peak   = (red > green) ? red : green;
    trough = (red < green) ? red : green;
    if (blue > peak) peak = blue;
    if (blue < trough) trough = blue;
    span = peak - trough;
    word = '0;
    word.brightness = chan_t'(peak);
    if (span > 0) begin
      word.saturation = SatW'((span * SatScale) / peak);
      // red wins ties over green, green over blue
      if (red >= peak) begin
        num = SixteenthsPerSector * (green - blue);
      end else if (green >= peak) begin
        num = SixteenthsPerSector * (SectorGreen * span + blue - red);
      end else begin
        num = SixteenthsPerSector * (SectorBlue * span + red - green);
      end
      // red sector below zero wraps by a full turn
      if (num < 0) num += SixteenthsFullTurn * span;
      word.hue = HueW'(num / span);
    end
    return word;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic chan_t nudge(input int unsigned base);
    int unsigned v;
    v = base + $urandom_range(0, 3);
    return (v > 255) ? 8'hFF : chan_t'(v);
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // offer one pixel word; returns just after the edge that takes it
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.red   <= r;
    pix_bus.green <= g;
    pix_bus.blue  <= b;
    // ready is settled by the falling edge, so the next rising edge takes the word
    do @(negedge clk_i); while (!pix_bus.ready);
    expected_hsv.push_back(predict_hsv(r, g, b));
    @(posedge clk_i);
  endtask

  task automatic park_pixel_bus();
    pix_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_drain();
    park_pixel_bus();
    while (expected_hsv.size() != 0) @(posedge clk_i);
  endtask

  // black, white, greys, primaries, ties and the wrapped red sector
  task automatic test_corner_pixels();
    foreach (CornerPixels[i]) begin
      send_pixel(CornerPixels[i][23:16], CornerPixels[i][15:8], CornerPixels[i][7:0]);
    end
  endtask

  task automatic test_uniform_pixels(input int unsigned count);
    repeat (count) begin
      send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
    end
  endtask

  // channels within a few steps of each other, grey included
  task automatic test_near_grey(input int unsigned count);
    int unsigned base;
    repeat (count) begin
      base = $urandom_range(0, 255);
      send_pixel(nudge(base), nudge(base), nudge(base));
    end
  endtask

  // two channels share the maximum
  task automatic test_tied_peaks(input int unsigned count);
    int unsigned peak;
    int unsigned other;
    repeat (count) begin
      peak  = $urandom_range(1, 255);
      other = $urandom_range(0, peak);
      case ($urandom_range(0, 2))
        0: begin
          send_pixel(chan_t'(peak), chan_t'(peak), chan_t'(other));
        end
        1: begin
          send_pixel(chan_t'(other), chan_t'(peak), chan_t'(peak));
        end
        default: begin
          send_pixel(chan_t'(peak), chan_t'(other), chan_t'(peak));
        end
      endcase
    end
  endtask

  // sender holds off until the pipeline has emptied
  task automatic test_pause_until_empty(input int unsigned rounds);
    repeat (rounds) begin
      test_uniform_pixels(10);
      wait_for_drain();
    end
  endtask

  // back-to-back words with no stalls on either side
  task automatic test_steady_stream(input int unsigned count);
    steady_flow = 1'b1;
    test_uniform_pixels(count);
    park_pixel_bus();
    steady_flow = 1'b0;
  endtask

  // sink stalls
  initial begin : sink_stalls
    int unsigned stall_left;
    int unsigned run_left;
    stall_left    = 0;
    run_left      = 0;
    hsv_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        hsv_bus.ready <= 1'b0;
      end else if (run_left != 0) begin
        run_left--;
        hsv_bus.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        run_left   = $urandom_range(0, 12);
        hsv_bus.ready <= (stall_left == 0);
      end
    end
  end

  // compare each hsv word taken with the oldest expectation
  always @(negedge clk_i) begin : hsv_checker
    hsv_word_t want;
    if (rst_ni && hsv_bus.valid && hsv_bus.ready) begin
      if (expected_hsv.size() == 0) begin
        $display("%0t: unexpected hsv word, expected none, actual hue %0d sat %0d val %0d",
                 $time, hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness);
        mismatch_count++;
      end else begin
        want = expected_hsv.pop_front();
        check_field("hue", 16'(want.hue), 16'(hsv_bus.hue));
        check_field("saturation", 16'(want.saturation), 16'(hsv_bus.saturation));
        check_field("brightness", 16'(want.brightness), 16'(hsv_bus.brightness));
      end
    end
  end

  // watchdog on cycles where no word moves
  always @(negedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no progress, %0d hsv words outstanding", $time, expected_hsv.size());
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run_tests
    rst_ni        = 1'b0;
    pix_bus.valid = 1'b0;
    pix_bus.red   = '0;
    pix_bus.green = '0;
    pix_bus.blue  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_uniform_pixels(1150);
    test_near_grey(200);
    test_tied_peaks(150);
    test_pause_until_empty(3);
    test_steady_stream(120);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_hsv.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
